[rtl/core/vsd_pkg.sv]
// shared types and constants for the varint stream decoder
package vsd_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned SHIFT_W = 5;

    localparam logic [6:0]       DATA_MASK  = 7'h7F;
    localparam logic [5:0]       FIRST_MASK = 6'h3F;
    localparam int unsigned      MORE_POS   = 7;
    localparam int unsigned      SIGN_POS   = 6;
    localparam logic [IDX_W-1:0] MAX_BYTES  = 3'd5;

    localparam logic FMT_UNSIGNED = 1'b0;
    localparam logic FMT_SIGNED   = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] value_bits;
        logic               error_flag;
        logic [IDX_W-1:0]   byte_length;
    } vsd_result_t;

endpackage

[rtl/core/vsd_step.sv]
// per-byte decode step: value state registers and the shift-or / negate logic
module vsd_step (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step_en,
    input  logic [vsd_pkg::BYTE_W-1:0]        in_byte,
    input  logic                              signed_format,
    output logic                              result_valid,
    output vsd_pkg::vsd_result_t              result
);

    logic [vsd_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [vsd_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        sign_reg, sign_next;
    logic                        fmt_reg, fmt_next;
    logic                        err_reg, err_next;

    logic [vsd_pkg::SHIFT_W-1:0] shift_amt;
    logic [vsd_pkg::VALUE_W-1:0] part;
    logic [vsd_pkg::IDX_W-1:0]   idx_inc;

    // 7 * index, one less in signed format (first byte held only 6 bits)
    assign shift_amt = vsd_pkg::SHIFT_W'({2'b00, idx_reg, 3'b000} - {5'b00000, idx_reg})
                     - vsd_pkg::SHIFT_W'(fmt_reg);
    assign part      = {25'd0, in_byte[6:0] & vsd_pkg::DATA_MASK} << shift_amt;
    assign idx_inc   = idx_reg + 3'd1;

    always_comb begin
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        sign_next    = sign_reg;
        fmt_next     = fmt_reg;
        err_next     = err_reg;
        result_valid = 1'b0;
        result       = '{value_bits: '0, error_flag: 1'b1,
                         byte_length: vsd_pkg::MAX_BYTES};

        if (err_reg) begin
            result_valid = 1'b1;
        end else if (idx_reg >= vsd_pkg::MAX_BYTES) begin
            // overlong value: latch error and drop the partial value
            err_next     = 1'b1;
            acc_next     = '0;
            idx_next     = '0;
            sign_next    = 1'b0;
            result_valid = 1'b1;
        end else begin
            if (idx_reg == '0) begin
                fmt_next = signed_format;
                if (signed_format == vsd_pkg::FMT_SIGNED) begin
                    sign_next = in_byte[vsd_pkg::SIGN_POS];
                    acc_next  = {26'd0, in_byte[5:0] & vsd_pkg::FIRST_MASK};
                end else begin
                    sign_next = 1'b0;
                    acc_next  = {25'd0, in_byte[6:0] & vsd_pkg::DATA_MASK};
                end
            end else begin
                acc_next = acc_reg | part;
            end
            idx_next = idx_inc;

            if (!in_byte[vsd_pkg::MORE_POS]) begin
                result_valid       = 1'b1;
                result.value_bits  = sign_next ? (32'd0 - acc_next) : acc_next;
                result.error_flag  = 1'b0;
                result.byte_length = idx_inc;
                acc_next  = '0;
                idx_next  = '0;
                sign_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            idx_reg  <= '0;
            sign_reg <= 1'b0;
            fmt_reg  <= vsd_pkg::FMT_UNSIGNED;
            err_reg  <= 1'b0;
        end else if (step_en) begin
            acc_reg  <= acc_next;
            idx_reg  <= idx_next;
            sign_reg <= sign_next;
            fmt_reg  <= fmt_next;
            err_reg  <= err_next;
        end
    end

endmodule

[rtl/core/varint_stream_decoder.sv]
// top level of the varint stream decoder: input word register, decode step, result register
// Usage:
//   s_ channel carries one encoded byte per word, with the value format in s_tuser.
//   The format is taken at a value's first byte: 0 unsigned LEB128, 1 sign-magnitude.
//   m_ channel carries one word per decoded value, on the value's last byte only.
//   A value longer than five bytes latches an error; from then on every input byte
//   gives a zero result with the error flag and length 5, until reset.
// Path: a value's last byte is held in the input register, then decoded into the result
//   register, which drives m_.
// Throughput: one byte per cycle while m_ does not stall; the input register and the result
//   register are both refilled in the cycle they are emptied.
// Reset: aresetn (synchronous, active low) empties both registers and clears the
//   partial value and the error latch.
// Stall: while m_tready is low and a result waits, the byte in the input register
//   holds and s_tready drops once that register is full; no word is lost.
module varint_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] signed_format
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value_bits, [34:32] byte_length, [39:35] zero
    output logic [0:0]  m_tuser    // [0] error_flag
);

    logic                            in_valid_reg;
    logic [vsd_pkg::BYTE_W-1:0]      in_byte_reg;
    logic                            in_fmt_reg;
    logic                            out_valid_reg;
    vsd_pkg::vsd_result_t            out_reg;

    logic                            advance;
    logic                            step_valid;
    vsd_pkg::vsd_result_t            step_result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    vsd_step u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .in_byte       (in_byte_reg),
        .signed_format (in_fmt_reg),
        .result_valid  (step_valid),
        .result        (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_fmt_reg  <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_valid) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.byte_length, out_reg.value_bits};
    assign m_tuser  = out_reg.error_flag;

endmodule
